>>> hdl/billboard_particle_quad_expander_macros.svh
// Assertion helpers shared by the expander RTL.
`ifndef BILLBOARD_PARTICLE_QUAD_EXPANDER_MACROS_SVH
`define BILLBOARD_PARTICLE_QUAD_EXPANDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BPQE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPQE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bpqe_pkg.sv
`timescale 1ns / 1ps
package bpqe_pkg;

    localparam int COORD_WIDTH_DEF = 20;
    localparam int EMIT_W          = 20;
    localparam int AXIS_W          = 16;
    localparam int SIZE_W          = 16;
    localparam int COLOR_W         = 32;
    localparam int DEN_W           = 17;
    localparam int QUO_W           = 16;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 60;
    localparam logic [DEN_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_RIGHT_AXIS,
        REG_UP_AXIS,
        REG_EMITTER_OFFSET,
        REG_START_COLOR,
        REG_MID_COLOR,
        REG_END_COLOR,
        REG_MID_POINT,
        REG_MID_ENABLE
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CORNER_TL,
        CORNER_TR,
        CORNER_BR,
        CORNER_BL
    } corner_t;

endpackage

>>> hdl/bpqe_div_pipe.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage. Requires num < den.
module bpqe_div_pipe
    import bpqe_pkg::*;
#(
    parameter int DW     = DEN_W,
    parameter int QW     = QUO_W,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DW-1:0]     in_num,
    input  logic [DW-1:0]     in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [QW-1:0]     out_quo,
    output logic [SIDE_W-1:0] out_side
);

    logic [QW-1:0]     v_reg;
    logic [DW-1:0]     r_reg    [QW];
    logic [DW-1:0]     d_reg    [QW];
    logic [QW-1:0]     q_reg    [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    logic [QW-1:0]     rdy;
    logic [DW-1:0]     r_next   [QW];
    logic [QW-1:0]     q_next   [QW];

    always_comb begin
        rdy[QW-1] = !v_reg[QW-1] || out_ready;
        for (int i = QW-2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        logic [DW:0]   rs;
        logic [DW-1:0] src_r [QW];
        logic [DW-1:0] src_d [QW];
        logic [QW-1:0] src_q [QW];
        src_r[0] = in_num;
        src_d[0] = in_den;
        src_q[0] = '0;
        for (int i = 1; i < QW; i++) begin
            src_r[i] = r_reg[i-1];
            src_d[i] = d_reg[i-1];
            src_q[i] = q_reg[i-1];
        end
        for (int i = 0; i < QW; i++) begin
            rs = {src_r[i], 1'b0};
            if (rs >= {1'b0, src_d[i]}) begin
                r_next[i] = DW'(rs - {1'b0, src_d[i]});
                q_next[i] = {src_q[i][QW-2:0], 1'b1};
            end else begin
                r_next[i] = rs[DW-1:0];
                q_next[i] = {src_q[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            r_reg[0]    <= r_next[0];
            q_reg[0]    <= q_next[0];
            d_reg[0]    <= in_den;
            side_reg[0] <= in_side;
        end
        for (int i = 1; i < QW; i++) begin
            if (rdy[i]) begin
                r_reg[i]    <= r_next[i];
                q_reg[i]    <= q_next[i];
                d_reg[i]    <= d_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < QW; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[QW-1];
    assign out_quo   = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

>>> hdl/billboard_particle_quad_expander.sv
`timescale 1ns / 1ps
`include "billboard_particle_quad_expander_macros.svh"
// Billboard particle quad expander.
// s_ channel: one particle per beat. s_tdata from bit 0 up: pos_x, pos_y,
// pos_z, age, lifetime, start_width, end_width, start_height, end_height;
// s_tlast marks the last particle of a batch.
// m_ channel: four vertex beats per particle, corners TL, TR, BR, BL.
// m_tdata: vert_x, vert_y, vert_z, vert_color; m_tuser: corner, end_of_batch;
// m_tlast is high on the fourth corner.
// Config: cfg_wr_en/cfg_addr/cfg_wr_data, write only, while idle.
// Pipeline: input register, 16-stage progress divider, size lerp stage,
// 16-stage gradient divider, axis/colour stage, vertex output register.
// The vertex port moves one corner per beat and so sets the particle rate;
// the pipeline itself takes a particle each cycle unless back-pressure stalls it.
// Reset (synchronous, aresetn low) empties the pipeline and loads the
// register defaults. A stalled m_tready holds the output beat; upstream
// stages keep filling bubbles, so s_tready drops only once every stage is full.
module billboard_particle_quad_expander
    import bpqe_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [CFG_DATA_W-1:0]             cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x, pos_y, pos_z, age, lifetime, start_w, end_w, start_h, end_h
    input  logic [((3*COORD_WIDTH+96+7)/8)*8-1:0] s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // vert_x, vert_y, vert_z, vert_color
    output logic [((3*COORD_WIDTH+32+7)/8)*8-1:0] m_tdata,
    // corner, end_of_batch
    output logic [2:0]                        m_tuser,
    output logic                              m_tlast
);

    localparam int CW      = COORD_WIDTH;
    localparam int IN_W    = 3*CW + 6*SIZE_W;
    localparam int OUT_W   = 3*CW + COLOR_W;
    localparam int OTD_W   = ((OUT_W+7)/8)*8;
    localparam int SW      = ((CW > EMIT_W) ? CW : EMIT_W) + 3;
    localparam int TERM_W  = 19;
    localparam int SIDE1_W = 3*CW + 4*SIZE_W + 2;
    localparam int SIDE2_W = 3*CW + 2*SIZE_W + DEN_W + 3;
    localparam longint SAT_HI_L = (longint'(1) <<< (CW-1)) - 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'(SAT_HI_L);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-SAT_HI_L - 1);

    // ---------------- configuration registers ----------------
    logic [3*AXIS_W-1:0] right_reg, up_reg;
    logic [3*EMIT_W-1:0] emit_reg;
    logic [COLOR_W-1:0]  c_start_reg, c_mid_reg, c_end_reg;
    logic [15:0]         mid_pt_reg;
    logic                mid_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_reg   <= 48'h0000_0000_4000;
            up_reg      <= 48'h0000_4000_0000;
            emit_reg    <= '0;
            c_start_reg <= 32'h8080_8080;
            c_mid_reg   <= 32'h8080_8080;
            c_end_reg   <= 32'h8080_8080;
            mid_pt_reg  <= '0;
            mid_en_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_RIGHT_AXIS:     right_reg   <= cfg_wr_data[3*AXIS_W-1:0];
                REG_UP_AXIS:        up_reg      <= cfg_wr_data[3*AXIS_W-1:0];
                REG_EMITTER_OFFSET: emit_reg    <= cfg_wr_data[3*EMIT_W-1:0];
                REG_START_COLOR:    c_start_reg <= cfg_wr_data[COLOR_W-1:0];
                REG_MID_COLOR:      c_mid_reg   <= cfg_wr_data[COLOR_W-1:0];
                REG_END_COLOR:      c_end_reg   <= cfg_wr_data[COLOR_W-1:0];
                REG_MID_POINT:      mid_pt_reg  <= cfg_wr_data[15:0];
                REG_MID_ENABLE:     mid_en_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- ready chain ----------------
    logic in_v_reg, p_v_reg, m_v_reg, out_v_reg;
    logic div1_in_rdy, div1_out_v, div2_in_rdy, div2_out_v;
    logic in_rdy, p_rdy, m_rdy, out_load;
    logic [1:0] k_reg;

    assign out_load = m_v_reg && (!out_v_reg || m_tready);
    assign m_rdy    = !m_v_reg || (out_load && (k_reg == CORNER_BL));
    assign p_rdy    = !p_v_reg || div2_in_rdy;
    assign in_rdy   = !in_v_reg || div1_in_rdy;
    assign s_tready = in_rdy;

    // ---------------- input register ----------------
    logic [IN_W-1:0] in_data_reg;
    logic            in_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (in_rdy) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_rdy) begin
            in_data_reg <= s_tdata[IN_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    // ---------------- progress divider: age / lifetime ----------------
    logic [SIZE_W-1:0]  in_age, in_life;
    logic               in_sat;
    logic [SIDE1_W-1:0] side1_in, side1_out;
    logic [QUO_W-1:0]   q1;

    assign in_age   = in_data_reg[3*CW +: SIZE_W];
    assign in_life  = in_data_reg[3*CW+SIZE_W +: SIZE_W];
    assign in_sat   = (in_life == '0) || (in_age >= in_life);
    assign side1_in = {in_last_reg, in_sat, in_data_reg[3*CW+2*SIZE_W +: 4*SIZE_W],
                       in_data_reg[3*CW-1:0]};

    bpqe_div_pipe #(.DW(DEN_W), .QW(QUO_W), .SIDE_W(SIDE1_W)) u_div_prog (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_v_reg),
        .in_ready  (div1_in_rdy),
        .in_num    (in_sat ? '0 : {1'b0, in_age}),
        .in_den    ({1'b0, in_life}),
        .in_side   (side1_in),
        .out_valid (div1_out_v),
        .out_ready (p_rdy),
        .out_quo   (q1),
        .out_side  (side1_out)
    );

    // ---------------- size lerp and gradient set-up ----------------
    logic [DEN_W-1:0]  p;
    logic [SIZE_W-1:0] d1_sw, d1_ew, d1_sh, d1_eh;
    logic [33:0]       acc_w, acc_h;
    logic [DEN_W-1:0]  num2_next, den2_next, tdir_next;
    logic              direct_next, seg_next;

    assign p     = side1_out[SIDE1_W-2] ? ONE_Q16 : {1'b0, q1};
    assign d1_sw = side1_out[3*CW +: SIZE_W];
    assign d1_ew = side1_out[3*CW+SIZE_W +: SIZE_W];
    assign d1_sh = side1_out[3*CW+2*SIZE_W +: SIZE_W];
    assign d1_eh = side1_out[3*CW+3*SIZE_W +: SIZE_W];
    assign acc_w = 34'(d1_sw) * 34'(ONE_Q16 - p) + 34'(d1_ew) * 34'(p);
    assign acc_h = 34'(d1_sh) * 34'(ONE_Q16 - p) + 34'(d1_eh) * 34'(p);

    always_comb begin
        num2_next   = p - {1'b0, mid_pt_reg};
        den2_next   = ONE_Q16 - {1'b0, mid_pt_reg};
        tdir_next   = ONE_Q16;
        seg_next    = 1'b1;
        direct_next = 1'b0;
        if (!mid_en_reg) begin
            direct_next = 1'b1;
            tdir_next   = p;
            seg_next    = 1'b0;
        end else if (p < {1'b0, mid_pt_reg}) begin
            num2_next = p;
            den2_next = {1'b0, mid_pt_reg};
            seg_next  = 1'b0;
        end else begin
            // progress at the very end lands exactly on the end colour
            direct_next = (num2_next == den2_next);
        end
    end

    logic [SIZE_W-1:0] w_reg, h_reg;
    logic [3*CW-1:0]   p_pos_reg;
    logic              p_last_reg, p_seg_reg, p_direct_reg;
    logic [DEN_W-1:0]  p_num_reg, p_den_reg, p_tdir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (p_rdy) begin
            p_v_reg <= div1_out_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_rdy) begin
            w_reg        <= acc_w[31:16];
            h_reg        <= acc_h[31:16];
            p_pos_reg    <= side1_out[3*CW-1:0];
            p_last_reg   <= side1_out[SIDE1_W-1];
            p_seg_reg    <= seg_next;
            p_direct_reg <= direct_next;
            p_num_reg    <= direct_next ? '0 : num2_next;
            p_den_reg    <= den2_next;
            p_tdir_reg   <= tdir_next;
        end
    end

    // ---------------- gradient divider ----------------
    logic [SIDE2_W-1:0] side2_in, side2_out;
    logic [QUO_W-1:0]   q2;

    assign side2_in = {p_seg_reg, p_direct_reg, p_tdir_reg, p_last_reg, h_reg, w_reg,
                       p_pos_reg};

    bpqe_div_pipe #(.DW(DEN_W), .QW(QUO_W), .SIDE_W(SIDE2_W)) u_div_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p_v_reg),
        .in_ready  (div2_in_rdy),
        .in_num    (p_num_reg),
        .in_den    (p_den_reg),
        .in_side   (side2_in),
        .out_valid (div2_out_v),
        .out_ready (m_rdy),
        .out_quo   (q2),
        .out_side  (side2_out)
    );

    // ---------------- axis terms, base position, colour ----------------
    logic [SIZE_W-1:0]  d2_w, d2_h;
    logic [DEN_W-1:0]   t;
    logic [COLOR_W-1:0] ca, cb, color_next;
    logic signed [TERM_W-1:0] rt_next [3];
    logic signed [TERM_W-1:0] ut_next [3];
    logic signed [SW-1:0]     base_next [3];

    assign d2_w = side2_out[3*CW +: SIZE_W];
    assign d2_h = side2_out[3*CW+SIZE_W +: SIZE_W];
    assign t    = side2_out[SIDE2_W-2] ? side2_out[3*CW+2*SIZE_W+1 +: DEN_W] : {1'b0, q2};

    always_comb begin
        ca = c_start_reg;
        cb = c_end_reg;
        if (mid_en_reg) begin
            ca = side2_out[SIDE2_W-1] ? c_mid_reg : c_start_reg;
            cb = side2_out[SIDE2_W-1] ? c_end_reg : c_mid_reg;
        end
    end

    always_comb begin
        logic [7:0]  cs, ce, mag, step;
        logic [24:0] prod;
        for (int k = 0; k < 4; k++) begin
            cs   = ca[8*k +: 8];
            ce   = cb[8*k +: 8];
            mag  = (ce < cs) ? 8'(cs - ce) : 8'(ce - cs);
            prod = 25'(mag) * 25'(t);
            step = prod[23:16];
            color_next[8*k +: 8] = (ce < cs) ? 8'(cs - step) : 8'(cs + step);
        end
    end

    always_comb begin
        logic signed [AXIS_W:0] ws, hs;
        logic signed [33:0]     pr, pu;
        ws = signed'({1'b0, d2_w});
        hs = signed'({1'b0, d2_h});
        for (int c = 0; c < 3; c++) begin
            pr = 34'(signed'(right_reg[AXIS_W*c +: AXIS_W])) * 34'(ws) + 34'sd8192;
            pu = 34'(signed'(up_reg[AXIS_W*c +: AXIS_W])) * 34'(hs) + 34'sd8192;
            rt_next[c]   = TERM_W'(pr >>> 14);
            ut_next[c]   = TERM_W'(pu >>> 14);
            base_next[c] = SW'(signed'(side2_out[CW*c +: CW]))
                         + SW'(signed'(emit_reg[EMIT_W*c +: EMIT_W]));
        end
    end

    logic signed [TERM_W-1:0] rt_reg   [3];
    logic signed [TERM_W-1:0] ut_reg   [3];
    logic signed [SW-1:0]     base_reg [3];
    logic [COLOR_W-1:0]       color_reg;
    logic                     m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
            k_reg   <= CORNER_TL;
        end else begin
            if (m_rdy) begin
                m_v_reg <= div2_out_v;
            end
            if (out_load) begin
                k_reg <= 2'(k_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_rdy) begin
            rt_reg     <= rt_next;
            ut_reg     <= ut_next;
            base_reg   <= base_next;
            color_reg  <= color_next;
            m_last_reg <= side2_out[3*CW+2*SIZE_W];
        end
    end

    // ---------------- corner expansion and output register ----------------
    logic            neg_r, neg_u;
    logic [3*CW-1:0] vert_next;

    assign neg_r = (k_reg == CORNER_TL) || (k_reg == CORNER_BL);
    assign neg_u = (k_reg == CORNER_BR) || (k_reg == CORNER_BL);

    always_comb begin
        logic signed [SW-1:0] v, r, u;
        for (int c = 0; c < 3; c++) begin
            r = SW'(rt_reg[c]);
            u = SW'(ut_reg[c]);
            v = base_reg[c] + (neg_r ? -r : r) + (neg_u ? -u : u);
            if (v > SAT_HI) begin
                v = SAT_HI;
            end else if (v < SAT_LO) begin
                v = SAT_LO;
            end
            vert_next[CW*c +: CW] = v[CW-1:0];
        end
    end

    logic [3*CW-1:0]    out_vert_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic [1:0]         out_corner_reg;
    logic               out_last_reg, out_eob_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_load) begin
            out_v_reg <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_vert_reg   <= vert_next;
            out_color_reg  <= color_reg;
            out_corner_reg <= k_reg;
            out_last_reg   <= (k_reg == CORNER_BL);
            out_eob_reg    <= (k_reg == CORNER_BL) && m_last_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OTD_W'({out_color_reg, out_vert_reg});
    assign m_tuser  = {out_eob_reg, out_corner_reg};
    assign m_tlast  = out_last_reg;

    // ---------------- checks ----------------
    `BPQE_ASSERT_NOW(a_last_on_fourth, m_tvalid, m_tlast == (m_tuser[1:0] == CORNER_BL), "tlast not on fourth corner")
    `BPQE_ASSERT_NOW(a_eob_needs_last, m_tvalid && m_tuser[2], m_tlast, "end of batch off the fourth corner")
    `BPQE_ASSERT_NEXT(a_corner_order, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser[1:0] == 2'($past(m_tuser[1:0]) + 2'd1)), "corner sequence broken")
    `BPQE_ASSERT_NOW(a_empty_takes_input, !in_v_reg, s_tready, "input stage empty but not ready")

endmodule
